FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked property, also during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// shared types, codes and the b3/s23 rule function
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int FUNC_W = 2;
  localparam int SEL_W  = 4;
  localparam int CELL_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd2;

  typedef struct packed {
    logic wr;
    logic step;
    logic rd;
  } cmd_t;

  // next state of one cell from its eight neighbors
  function automatic logic life_rule(input logic [7:0] nbr, input logic alive);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(nbr[i]);
    end
    return (n == BIRTH_COUNT) || (alive && (n == STAY_COUNT));
  endfunction

endpackage

FILE: design/lag_ctrl.sv
// ----------------------------------------------------------------------------
// lag_ctrl
// request decode and result strobe sequencing
// ----------------------------------------------------------------------------
module lag_ctrl
  import lag_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  output logic              busy,
  output logic              done,
  output cmd_t              cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cmd = '0;
    if (accept) begin
      case (func)
        FUNC_WRITE: cmd.wr   = 1'b1;
        FUNC_STEP:  cmd.step = 1'b1;
        FUNC_READ:  cmd.rd   = 1'b1;
        default:    cmd      = '0;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_DONE : S_IDLE;
      S_DONE:  state_next = accept ? S_DONE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign done = (state == S_DONE);

endmodule

FILE: design/lag_datapath.sv
// ----------------------------------------------------------------------------
// lag_datapath
// board registers, per-cell rule units, row write and row read
// ----------------------------------------------------------------------------
module lag_datapath
  import lag_pkg::*;
#(
  parameter int SIZE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [SEL_W-1:0]  row_sel,
  input  logic [CELL_W-1:0] row_cells,
  output logic [CELL_W-1:0] cells_out
);

  localparam int WIDE = (SIZE > CELL_W) ? SIZE : CELL_W;

  logic [SIZE-1:0] board [SIZE];
  logic [SIZE-1:0] gen   [SIZE];
  logic [SIZE+1:0] pad   [SIZE+2];
  logic [WIDE-1:0] wr_wide;
  logic [WIDE-1:0] rd_wide;
  logic [SIZE-1:0] rd_row;

  // zero frame around the board
  assign pad[0]      = '0;
  assign pad[SIZE+1] = '0;

  for (genvar r = 0; r < SIZE; r++) begin : g_row
    assign pad[r+1] = {1'b0, board[r], 1'b0};
    for (genvar c = 0; c < SIZE; c++) begin : g_col
      assign gen[r][c] = life_rule({pad[r][c+2:c], pad[r+1][c+2], pad[r+1][c],
                                    pad[r+2][c+2:c]}, board[r][c]);
    end
  end

  assign wr_wide = WIDE'(row_cells);

  always_comb begin
    rd_row = '0;
    for (int r = 0; r < SIZE; r++) begin
      if (int'(row_sel) == r) begin
        rd_row = rd_row | board[r];
      end
    end
  end

  assign rd_wide = WIDE'(rd_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      board <= '{default: '0};
    end else if (cmd.step) begin
      board <= gen;
    end else if (cmd.wr) begin
      for (int r = 0; r < SIZE; r++) begin
        if (int'(row_sel) == r) begin
          board[r] <= wr_wide[SIZE-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr || cmd.step || cmd.rd) begin
      cells_out <= cmd.rd ? rd_wide[CELL_W-1:0] : '0;
    end else begin
      cells_out <= '0;
    end
  end

endmodule

FILE: design/life_automaton_generation.sv
// ----------------------------------------------------------------------------
// life_automaton_generation
// b3/s23 life board with row write, generation step and row read
// ----------------------------------------------------------------------------
// A request is taken in any cycle with start high; busy stays low, so one
// request per clock is sustained. Its result appears on cells_out with done
// high in the cycle right after acceptance, for that one cycle only, and the
// receiver must take it then. A step updates every cell of the board at once
// through one rule unit per cell. Reads return the low 16 columns of
// the row, writes and steps return zero, and rows outside the board read as
// zero and ignore writes. Reset clears the board to all dead.
`include "assert_macros.svh"

module life_automaton_generation
  import lag_pkg::*;
#(
  parameter int SIZE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [SEL_W-1:0]  row_sel,
  input  logic [CELL_W-1:0] row_cells,
  output logic              done,
  output logic [CELL_W-1:0] cells_out
);

  cmd_t cmd;

  lag_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lag_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row_sel   (row_sel),
    .row_cells (row_cells),
    .cells_out (cells_out)
  );

  `ASSERT_CLK(a_done_after_request, clk, rst, (start && !busy) |=> done)
  `ASSERT_CLK(a_no_done_without_request, clk, rst, !(start && !busy) |=> !done)
  `ASSERT_CLK(a_data_on_read, clk, rst, done && cells_out != '0 |-> $past(func) == FUNC_READ)
  `ASSERT_ALWAYS(a_reset_clears_done, clk, $past(rst) |-> !done)

endmodule

FILE: test/life_automaton_generation_checker.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_checker
// watches requests and results of the life board, keeps its own copy of
// the board, predicts each result and compares it with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_automaton_generation_checker
  import lag_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [SEL_W-1:0]  row_sel,
  input  logic [CELL_W-1:0] row_cells,
  input  logic              done,
  input  logic [CELL_W-1:0] cells_out,
  output int                errors,
  output int                pending
);

  localparam int GRID_ROWS = 16;

  logic [CELL_W-1:0] board_copy [GRID_ROWS];
  logic [CELL_W-1:0] expected_cells [$];

  function automatic void next_generation();
    logic [CELL_W-1:0] next_rows [GRID_ROWS];
    int r, c, dr, dc, rr, cc, n;
    for (r = 0; r < GRID_ROWS; r++) begin
      next_rows[r] = '0;
      for (c = 0; c < GRID_ROWS; c++) begin
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                cc >= 0 && cc < GRID_ROWS) begin
              n += int'(board_copy[rr][cc]);
            end
          end
        end
        next_rows[r][c] = (n == int'(BIRTH_COUNT)) ||
                          (board_copy[r][c] && n == int'(STAY_COUNT));
      end
    end
    board_copy = next_rows;
  endfunction

  function automatic logic [CELL_W-1:0] board_request(input logic [FUNC_W-1:0] f,
                                                      input logic [SEL_W-1:0]  sel,
                                                      input logic [CELL_W-1:0] cells);
    logic [CELL_W-1:0] row;
    row = '0;
    case (f)
      FUNC_WRITE: begin
        if (int'(sel) < GRID_ROWS) board_copy[sel] = cells;
      end
      FUNC_STEP: begin
        next_generation();
      end
      FUNC_READ: begin
        if (int'(sel) < GRID_ROWS) row = board_copy[sel];
      end
      default: ;
    endcase
    return row;
  endfunction

  always @(posedge clk) begin
    logic [CELL_W-1:0] want;
    if (rst) begin
      for (int r = 0; r < GRID_ROWS; r++) board_copy[r] = '0;
      expected_cells.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result: cells_out %h", cells_out);
          errors++;
        end else begin
          want = expected_cells.pop_front();
          if (cells_out !== want) begin
            $error("cells_out mismatch: expected %h, actual %h", want, cells_out);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        expected_cells.push_back(board_request(func, row_sel, row_cells));
      end
    end
    pending = expected_cells.size();
  end

endmodule

FILE: test/life_automaton_generation_tb.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_tb
// drives directed and random row writes, generation steps and row reads
// into the life board with random gaps; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_automaton_generation_tb;
  import lag_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] func;
  logic [SEL_W-1:0]  row_sel;
  logic [CELL_W-1:0] row_cells;
  logic              done;
  logic [CELL_W-1:0] cells_out;

  int errors;
  int pending;
  int cycles = 0;
  int sent;
  bit no_gaps;

  life_automaton_generation DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .row_sel   (row_sel),
    .row_cells (row_cells),
    .done      (done),
    .cells_out (cells_out)
  );

  life_automaton_generation_checker board_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .row_sel   (row_sel),
    .row_cells (row_cells),
    .done      (done),
    .cells_out (cells_out),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold start low for random gaps, then keep the request up until taken
  task automatic issue(input logic [FUNC_W-1:0] f, input logic [SEL_W-1:0] sel,
                       input logic [CELL_W-1:0] cells);
    while (!no_gaps && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    func      <= f;
    row_sel   <= sel;
    row_cells <= cells;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  function automatic logic [CELL_W-1:0] random_row();
    case ($urandom_range(3))
      0: return CELL_W'($urandom & $urandom & $urandom);
      1: return CELL_W'($urandom & $urandom);
      2: return CELL_W'($urandom);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // writes a few rows, runs some generations and reads rows back
  task automatic pattern_run();
    int k;
    k = $urandom_range(6, 1);
    repeat (k) issue(FUNC_WRITE, SEL_W'($urandom), random_row());
    k = $urandom_range(4, 1);
    repeat (k) issue(FUNC_STEP, SEL_W'($urandom), CELL_W'($urandom));
    if ($urandom_range(3) == 0) begin
      for (int r = 0; r < 16; r++) issue(FUNC_READ, SEL_W'(r), CELL_W'($urandom));
    end else begin
      k = $urandom_range(5, 1);
      repeat (k) issue(FUNC_READ, SEL_W'($urandom), CELL_W'($urandom));
    end
  endtask

  initial begin
    sent      = 0;
    no_gaps   = 1'b0;
    rst       <= 1'b1;
    start     <= 1'b0;
    func      <= FUNC_WRITE;
    row_sel   <= '0;
    row_cells <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full edge rows, reads at the edges and of an empty row, unused code
    issue(FUNC_READ, 4'd3, 16'h0000);
    issue(FUNC_WRITE, 4'd0, 16'hFFFF);
    issue(FUNC_WRITE, 4'd15, 16'hFFFF);
    issue(FUNC_READ, 4'd0, 16'h0000);
    issue(FUNC_READ, 4'd15, 16'hFFFF);
    issue(FUNC_NONE, 4'd0, 16'h0000);
    issue(FUNC_READ, 4'd0, 16'h0000);
    issue(FUNC_STEP, 4'd15, 16'hFFFF);
    issue(FUNC_READ, 4'd0, 16'h0000);
    issue(FUNC_READ, 4'd1, 16'h0000);
    issue(FUNC_READ, 4'd14, 16'h0000);
    issue(FUNC_READ, 4'd15, 16'h0000);
    // blinker on the left edge, block in a corner, checkerboard band
    issue(FUNC_WRITE, 4'd0, 16'hC000);
    issue(FUNC_WRITE, 4'd1, 16'hC000);
    issue(FUNC_WRITE, 4'd15, 16'h0000);
    issue(FUNC_WRITE, 4'd14, 16'h0000);
    issue(FUNC_WRITE, 4'd8, 16'h0007);
    issue(FUNC_WRITE, 4'd11, 16'hAAAA);
    issue(FUNC_WRITE, 4'd12, 16'h5555);
    issue(FUNC_STEP, 4'd0, 16'h0000);
    issue(FUNC_READ, 4'd0, 16'h0000);
    issue(FUNC_READ, 4'd7, 16'h0000);
    issue(FUNC_READ, 4'd9, 16'h0000);
    issue(FUNC_READ, 4'd11, 16'h0000);
    issue(FUNC_READ, 4'd12, 16'h0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = (sent >= 250 && sent < 350);
      if ($urandom_range(99) < 70) begin
        pattern_run();
      end else begin
        issue(FUNC_W'($urandom), SEL_W'($urandom), CELL_W'($urandom));
      end
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lag_pkg.sv
design/lag_ctrl.sv
design/lag_datapath.sv
design/life_automaton_generation.sv
test/life_automaton_generation_checker.sv
test/life_automaton_generation_tb.sv
